### rtl/core/hoc_pkg.sv
// Shared constants, codes and the controller state type of the hash occurrence counter.
// Depends on nothing; every other file of the block refers to it by scoped names.
package hoc_pkg;

  // Default configuration of the table.
  localparam int unsigned CAPACITY_DEF   = 1024;
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Fixed field widths of the channels and the register.
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned OUT_COUNT_W = 16;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned LIMIT_W     = 11;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 11'd512;

  // Slot tags.
  localparam int unsigned TAG_W = 2;
  localparam logic [TAG_W-1:0] TAG_EMPTY = 2'd0;
  localparam logic [TAG_W-1:0] TAG_LIVE  = 2'd1;
  localparam logic [TAG_W-1:0] TAG_TOMB  = 2'd2;

  // Operation codes. The unused code behaves as a lookup.
  localparam logic [FUNC_W-1:0] FUNC_INC    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEC    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

  // Key bits folded into the remainder per cycle when the capacity is not a power of two.
  localparam int unsigned MOD_DIGIT = 4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_UPDATE
  } hoc_state_t;

endpackage

### rtl/core/hoc_if.sv
// Valid/ready channel interfaces for the request and result beats of the counter.
// Depends on hoc_pkg for the payload widths.
interface hoc_in_if;
  logic                             valid;
  logic                             ready;
  logic [hoc_pkg::FUNC_W-1:0]       func;
  logic [hoc_pkg::KEY_W-1:0]        key;

  modport source (output valid, output func, output key, input ready);
  modport sink   (input valid, input func, input key, output ready);
endinterface

interface hoc_out_if;
  logic                             valid;
  logic                             ready;
  logic [hoc_pkg::OUT_COUNT_W-1:0]  count;
  logic [hoc_pkg::STATUS_W-1:0]     status;

  modport source (output valid, output count, output status, input ready);
  modport sink   (input valid, input count, input status, output ready);
endinterface

### rtl/core/hoc_slot_ram.sv
// Slot storage of the counter: one write port and one read port, read data registered.
// Depends on hoc_pkg for the default depth.
module hoc_slot_ram #(
  parameter int unsigned DEPTH  = hoc_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_W = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/hash_occurrence_counter.sv
// Top level of the hash occurrence counter: controller, probe datapath and result register.
// Depends on hoc_pkg, the channel interfaces in hoc_if and the slot memory hoc_slot_ram.
//
//   channel  | dir | beat payload         | handshake
//   ---------+-----+----------------------+-------------------------------
//   in_if    | in  | func, key            | valid/ready
//   out_if   | out | count, status        | valid/ready, registered
//   cfg      | in  | cfg_wdata (limit)    | cfg_we, written at once
//
// One request is worked on at a time. Each request passes from idle through the probe
// state, where the slots are examined one after another until one decides, and the update
// state back to idle; any capacity that is not a power of two first passes the hash state
// to reduce the key modulo the capacity, MOD_DIGIT key bits per step. The probe loop
// through the single read port of the slot memory, one slot per cycle, sets the rate.
// After reset a clearing pass marks every slot empty; no request is accepted during it.
// A stalled result does not block the next request, which waits in its final state
// only until the result register is free.
module hash_occurrence_counter #(
  parameter int unsigned CAPACITY   = hoc_pkg::CAPACITY_DEF,
  parameter int unsigned COUNT_BITS = hoc_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  hoc_in_if.sink                       in_if,
  hoc_out_if.source                    out_if,
  input  logic                         cfg_we,
  input  logic [hoc_pkg::LIMIT_W-1:0]  cfg_wdata
);

  localparam int unsigned IDX_W     = $clog2(CAPACITY);
  localparam int unsigned LIVE_W    = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W     = (LIVE_W > hoc_pkg::LIMIT_W) ? LIVE_W : hoc_pkg::LIMIT_W;
  localparam bit          IS_POW2   = (CAPACITY == (1 << IDX_W));
  localparam int unsigned MOD_STEPS = hoc_pkg::KEY_W / hoc_pkg::MOD_DIGIT;
  localparam int unsigned STEP_W    = $clog2(MOD_STEPS);

  localparam logic [IDX_W:0]        MOD_C     = (IDX_W + 1)'(CAPACITY);
  localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(CAPACITY - 1);
  localparam logic [STEP_W-1:0]     LAST_STEP = STEP_W'(MOD_STEPS - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // One memory word holds the whole slot.
  typedef struct packed {
    logic [hoc_pkg::TAG_W-1:0] tag;
    logic [hoc_pkg::KEY_W-1:0] key;
    logic [COUNT_BITS-1:0]     cnt;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  // Controller and bookkeeping registers.
  hoc_pkg::hoc_state_t state_r, state_nxt;
  logic [IDX_W-1:0]            probe_addr_r;  // clear pointer, then probe read address
  logic                        rd_vld_r;      // memory output belongs to chk_addr_r
  logic [LIVE_W-1:0]           live_r;
  logic [hoc_pkg::LIMIT_W-1:0] limit_r;
  logic                        out_valid_r;

  // Request and probe datapath registers.
  logic [hoc_pkg::FUNC_W-1:0]  func_r;
  logic [hoc_pkg::KEY_W-1:0]   key_r;
  logic [hoc_pkg::KEY_W-1:0]   kshf_r;
  logic [IDX_W-1:0]            rem_r;
  logic [STEP_W-1:0]           step_r;
  logic [IDX_W-1:0]            chk_addr_r;
  logic [IDX_W-1:0]            chk_cnt_r;
  logic                        tomb_vld_r;
  logic [IDX_W-1:0]            tomb_addr_r;
  logic                        hit_r;
  logic                        dst_vld_r;
  logic [IDX_W-1:0]            tgt_addr_r;
  logic [COUNT_BITS-1:0]       hit_cnt_r;
  logic [hoc_pkg::OUT_COUNT_W-1:0] out_count_r;
  logic [hoc_pkg::STATUS_W-1:0]    out_status_r;

  // Combinational signals.
  logic              in_acc;
  logic              out_free;
  logic [IDX_W-1:0]  rem_step;
  logic [IDX_W-1:0]  probe_addr_inc;
  slot_t             rd_slot;
  logic [SLOT_W-1:0] rd_data;
  logic              is_empty, is_live, is_match, is_tomb;
  logic              tomb_vld_cur;
  logic [IDX_W-1:0]  tomb_addr_cur;
  logic              probe_end;
  logic              tbl_full;
  logic              wr_need;
  slot_t             wr_slot;
  slot_t             clr_slot;
  logic              live_inc, live_dec;
  logic [COUNT_BITS-1:0]            res_cnt;
  logic [31:0]                      res_cnt_ext;
  logic [hoc_pkg::STATUS_W-1:0]     res_stat;
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr;
  slot_t             ram_wslot;

  assign in_acc   = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;

  assign out_if.valid  = out_valid_r;
  assign out_if.count  = out_count_r;
  assign out_if.status = out_status_r;

  // Key modulo capacity, MOD_DIGIT key bits per cycle, most significant first.
  // Each step doubles the remainder, adds a bit and subtracts the capacity once if needed.
  always_comb begin
    logic [IDX_W-1:0] rem_v;
    logic [IDX_W:0]   trial_v;
    rem_v   = rem_r;
    trial_v = '0;
    for (int i = 0; i < int'(hoc_pkg::MOD_DIGIT); i++) begin
      trial_v = {rem_v, kshf_r[hoc_pkg::KEY_W-1-i]};
      if (trial_v >= MOD_C) begin
        trial_v = trial_v - MOD_C;
      end
      rem_v = trial_v[IDX_W-1:0];
    end
    rem_step = rem_v;
  end

  assign probe_addr_inc = (probe_addr_r == LAST_IDX) ? '0 : probe_addr_r + 1'b1;

  // Examination of the slot that the memory returns this cycle.
  assign rd_slot       = slot_t'(rd_data);
  assign is_empty      = (rd_slot.tag == hoc_pkg::TAG_EMPTY);
  assign is_live       = (rd_slot.tag == hoc_pkg::TAG_LIVE);
  assign is_match      = is_live && (rd_slot.key == key_r);
  assign is_tomb       = !is_empty && !is_live;
  assign tomb_vld_cur  = tomb_vld_r || is_tomb;
  assign tomb_addr_cur = tomb_vld_r ? tomb_addr_r : chk_addr_r;
  assign probe_end     = rd_vld_r && (is_empty || is_match || (chk_cnt_r == LAST_IDX));

  assign tbl_full = CMP_W'(live_r) >= CMP_W'(limit_r);

  // Result and write-back of the finished probe.
  always_comb begin
    res_cnt  = '0;
    res_stat = hoc_pkg::STAT_OK;
    wr_need  = 1'b0;
    wr_slot  = '{tag: hoc_pkg::TAG_LIVE, key: key_r, cnt: hit_cnt_r};
    live_inc = 1'b0;
    live_dec = 1'b0;
    unique case (func_r)
      hoc_pkg::FUNC_INC: begin
        if (hit_r) begin
          res_cnt     = (hit_cnt_r == COUNT_MAX) ? hit_cnt_r : hit_cnt_r + 1'b1;
          wr_slot.cnt = res_cnt;
          wr_need     = 1'b1;
        end else if (tbl_full || !dst_vld_r) begin
          res_stat = hoc_pkg::STAT_FULL;
        end else begin
          res_cnt     = COUNT_BITS'(1);
          wr_slot.cnt = res_cnt;
          wr_need     = 1'b1;
          live_inc    = 1'b1;
        end
      end
      hoc_pkg::FUNC_DEC: begin
        if (hit_r) begin
          res_cnt     = (hit_cnt_r != '0) ? hit_cnt_r - 1'b1 : '0;
          wr_slot.cnt = res_cnt;
          wr_need     = 1'b1;
          // A count that reaches zero leaves a tombstone behind.
          if (res_cnt == '0) begin
            wr_slot.tag = hoc_pkg::TAG_TOMB;
            live_dec    = (live_r != '0);
          end
        end else begin
          res_stat = hoc_pkg::STAT_NOT_FOUND;
        end
      end
      default: begin
        if (hit_r) begin
          res_cnt = hit_cnt_r;
        end
      end
    endcase
  end

  assign res_cnt_ext = 32'(res_cnt);
  assign clr_slot    = '{tag: hoc_pkg::TAG_EMPTY, key: '0, cnt: '0};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hoc_pkg::ST_CLEAR: begin
        if (probe_addr_r == LAST_IDX) begin
          state_nxt = hoc_pkg::ST_IDLE;
        end
      end
      hoc_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = IS_POW2 ? hoc_pkg::ST_PROBE : hoc_pkg::ST_HASH;
        end
      end
      hoc_pkg::ST_HASH: begin
        if (step_r == LAST_STEP) begin
          state_nxt = hoc_pkg::ST_PROBE;
        end
      end
      hoc_pkg::ST_PROBE: begin
        if (probe_end) begin
          state_nxt = hoc_pkg::ST_UPDATE;
        end
      end
      hoc_pkg::ST_UPDATE: begin
        if (out_free) begin
          state_nxt = hoc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hoc_pkg::ST_CLEAR;
    endcase
  end

  // Controller outputs: handshake and memory ports.
  always_comb begin
    in_if.ready = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = tgt_addr_r;
    ram_wslot   = wr_slot;
    unique case (state_r)
      hoc_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = probe_addr_r;
        ram_wslot = clr_slot;
      end
      hoc_pkg::ST_IDLE: begin
        in_if.ready = 1'b1;
      end
      hoc_pkg::ST_PROBE: begin
        ram_re = 1'b1;
      end
      hoc_pkg::ST_UPDATE: begin
        ram_we = out_free && wr_need;
      end
      default: begin
      end
    endcase
  end

  hoc_slot_ram #(
    .DEPTH  (CAPACITY),
    .DATA_W (SLOT_W)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wslot),
    .rd_en   (ram_re),
    .rd_addr (probe_addr_r),
    .rd_data (rd_data)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= hoc_pkg::ST_CLEAR;
      probe_addr_r <= '0;
      rd_vld_r     <= 1'b0;
      live_r       <= '0;
      limit_r      <= hoc_pkg::LIMIT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == hoc_pkg::ST_PROBE) && !probe_end;

      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end

      unique case (state_r)
        hoc_pkg::ST_CLEAR: begin
          probe_addr_r <= probe_addr_inc;
        end
        hoc_pkg::ST_IDLE: begin
          if (in_acc && IS_POW2) begin
            probe_addr_r <= in_if.key[IDX_W-1:0];
          end
        end
        hoc_pkg::ST_HASH: begin
          if (step_r == LAST_STEP) begin
            probe_addr_r <= rem_step;
          end
        end
        hoc_pkg::ST_PROBE: begin
          probe_addr_r <= probe_addr_inc;
        end
        default: begin
        end
      endcase

      if (state_r == hoc_pkg::ST_UPDATE && out_free) begin
        out_valid_r <= 1'b1;
        if (live_inc) begin
          live_r <= live_r + 1'b1;
        end else if (live_dec) begin
          live_r <= live_r - 1'b1;
        end
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r     <= in_if.func;
      key_r      <= in_if.key;
      kshf_r     <= in_if.key;
      rem_r      <= '0;
      step_r     <= '0;
      chk_cnt_r  <= '0;
      tomb_vld_r <= 1'b0;
    end

    if (state_r == hoc_pkg::ST_HASH) begin
      kshf_r <= kshf_r << hoc_pkg::MOD_DIGIT;
      rem_r  <= rem_step;
      step_r <= step_r + 1'b1;
    end

    if (state_r == hoc_pkg::ST_PROBE) begin
      chk_addr_r <= probe_addr_r;
      if (rd_vld_r) begin
        chk_cnt_r <= chk_cnt_r + 1'b1;
        if (!tomb_vld_r && is_tomb) begin
          tomb_vld_r  <= 1'b1;
          tomb_addr_r <= chk_addr_r;
        end
      end
      if (probe_end) begin
        hit_r      <= is_match;
        hit_cnt_r  <= rd_slot.cnt;
        dst_vld_r  <= tomb_vld_cur || is_empty;
        tgt_addr_r <= is_match ? chk_addr_r : (tomb_vld_cur ? tomb_addr_cur : chk_addr_r);
      end
    end

    if (state_r == hoc_pkg::ST_UPDATE && out_free) begin
      out_count_r  <= res_cnt_ext[hoc_pkg::OUT_COUNT_W-1:0];
      out_status_r <= res_stat;
    end
  end

endmodule

### rtl/core/hoc_checker.sv
// Port-level checks for the hash occurrence counter, bound to its top level.
// Depends on hoc_pkg for the status codes and field widths.
module hoc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [hoc_pkg::OUT_COUNT_W-1:0] out_count,
  input logic [hoc_pkg::STATUS_W-1:0]    out_status
);

  // A result that is not taken stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_count) && $stable(out_status))
    else $error("result beat dropped or changed while stalled");

  // Requests are worked one at a time: right after a request beat no other is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while the previous one is in progress");

  // A refused or missing key reports a zero count.
  a_err_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != hoc_pkg::STAT_OK |-> out_count == '0)
    else $error("error status with nonzero count");

  // The clearing pass after reset keeps requests out.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request accepted before the slot clearing pass");

endmodule

bind hash_occurrence_counter hoc_checker u_hoc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_count  (out_if.count),
  .out_status (out_if.status)
);
